@@ rtl/ttsw_pkg.sv @@
package ttsw_pkg;

  parameter int COLUMNS_DEF      = 128;
  parameter int RING_LINES_DEF   = 1024;
  parameter int VISIBLE_ROWS_DEF = 48;
  parameter int TAB_STOP_DEF     = 4;

  parameter int CELL_W = 16;

  typedef enum logic [1:0] {
    OP_PRINT   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_SCROLL  = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic {
    CFG_DEFAULT_FG = 1'b0,
    CFG_DEFAULT_BG = 1'b1
  } cfg_e;

  parameter logic [3:0] DEFAULT_FG_RST = 4'd9;
  parameter logic [3:0] DEFAULT_BG_RST = 4'd0;

  parameter logic [9:0] WRAP_MAX = 10'd1023;

  parameter logic [7:0] CH_NUL    = 8'h00;
  parameter logic [7:0] CH_TAB    = 8'h09;
  parameter logic [7:0] CH_LF     = 8'h0A;
  parameter logic [7:0] CH_CR     = 8'h0D;
  parameter logic [7:0] CH_SPACE  = 8'h20;
  parameter logic [7:0] CH_DOLLAR = 8'h24;
  parameter logic [7:0] CH_ZERO   = 8'h30;
  parameter logic [7:0] CH_NINE   = 8'h39;
  parameter logic [7:0] CH_BSLASH = 8'h5C;
  parameter logic [7:0] CH_N      = 8'h6E;
  parameter logic [7:0] CH_R      = 8'h72;
  parameter logic [7:0] CH_T      = 8'h74;

  // color index to native color, indexes above nine saturate
  function automatic logic [3:0] native_color(logic [3:0] idx);
    logic [3:0] c;
    case (idx)
      4'd0:    c = 4'h0;
      4'd1:    c = 4'hF;
      4'd2:    c = 4'h9;
      4'd3:    c = 4'hA;
      4'd4:    c = 4'hC;
      4'd5:    c = 4'hB;
      4'd6:    c = 4'hE;
      4'd7:    c = 4'hD;
      4'd8:    c = 4'h6;
      default: c = 4'h7;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] default_attr(logic [3:0] fg, logic [3:0] bg);
    return {native_color(bg), native_color(fg)};
  endfunction

  parameter logic [CELL_W-1:0] RESET_BLANK =
    {default_attr(DEFAULT_FG_RST, DEFAULT_BG_RST), CH_SPACE};

endpackage

@@ rtl/text_terminal_scrollback_writer_unit.sv @@
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// command  | start / busy         | op_i char_in_i scroll_amount_i view_row_i
//          |                      | view_column_i
// result   | done_o (one cycle)   | cell_char_o cell_attr_o scroll_pos_o
//          |                      | line_count_o scrolled_up_o scroll_changed_o
// config   | cfg_we_i             | cfg_index_i cfg_data_i
//
// a beat is taken when start is high and busy is low; one result beat follows
// prefix byte, color digit, string end: straight to done; plain byte, scroll: a
// put or scroll state; read: a step per ring wrap of the row index, then a ram
// read; tab: a put per cell written; line advance: a row clear of COLUMNS cells
// (single port ram, one cell written a cycle); carriage return: clears the wrapped
// and current rows; a wrap adds a row clear; after reset the cell ram is swept;
// the result beat cannot be stalled; a new command is taken in its cycle
module text_terminal_scrollback_writer_unit
  import ttsw_pkg::*;
#(
  parameter int COLUMNS      = ttsw_pkg::COLUMNS_DEF,
  parameter int RING_LINES   = ttsw_pkg::RING_LINES_DEF,
  parameter int VISIBLE_ROWS = ttsw_pkg::VISIBLE_ROWS_DEF,
  parameter int TAB_STOP     = ttsw_pkg::TAB_STOP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [7:0]         char_in_i,
  input  logic signed [11:0] scroll_amount_i,
  input  logic [5:0]         view_row_i,
  input  logic [6:0]         view_column_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  output logic               done_o,
  output logic [7:0]         cell_char_o,
  output logic [7:0]         cell_attr_o,
  output logic [9:0]         scroll_pos_o,
  output logic [10:0]        line_count_o,
  output logic               scrolled_up_o,
  output logic               scroll_changed_o
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int CLW   = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(RING_LINES);
  localparam int LW    = $clog2(RING_LINES + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = RING_LINES * (2 ** CW);
  localparam int IW    = $clog2(2 * RING_LINES + 64);
  localparam int SW    = ((LW > 12) ? LW : 12) + 2;
  localparam int TMW   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_PUT,
    S_ROWCLR,
    S_SCROLL,
    S_RDMOD,
    S_RDDATA,
    S_DONE
  } state_e;

  state_e state_q, ret_q;

  logic [3:0]         default_fg_q, default_bg_q;
  logic [RW-1:0]      head_q;
  logic [LW-1:0]      lh_q;
  logic [9:0]         wrap_q;
  logic [CLW-1:0]     col_q;
  logic [TMW-1:0]     col_mod_q;
  logic [LW-1:0]      vt_q;
  logic               esc_q, color_q;
  logic [7:0]         attr_q;
  logic [AW-1:0]      sweep_q;
  logic [RW-1:0]      clr_row_q;
  logic [CW-1:0]      ccol_q;
  logic [RW-1:0]      rows_left_q;
  logic [7:0]         put_ch_q, put2_ch_q;
  logic               put2_q, tab_q;
  logic signed [11:0] amt_q;
  logic [IW-1:0]      idx_q;
  logic [CW-1:0]      rcol_q;
  logic [7:0]         cell_char_q, cell_attr_q;
  logic               chg_q;

  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic [7:0]        dflt_attr;
  logic [CELL_W-1:0] blank;
  logic [LW:0]       cur_sum, adv_sum;
  logic [RW-1:0]     cur_row, adv_row, head_inc, row_dec;
  logic              adv_full;
  logic [RW-1:0]     adv_head;
  logic [LW-1:0]     adv_lh, adv_vt, lhm1, lh_cr, maxv, vt_clamp;
  logic [RW-1:0]     cr_w;
  logic [TMW-1:0]    mod_inc;
  logic signed [SW-1:0] ns, smax, ns_cl;
  logic [LW-1:0]     scroll_vt;
  logic              accept, is_esc, is_digit, esc_plain;
  logic              is_nl, is_cr, is_tab;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign dflt_attr = default_attr(default_fg_q, default_bg_q);
  assign blank     = {dflt_attr, CH_SPACE};

  // row of the newest line and of the row taken by a line advance
  always_comb begin
    cur_sum = (LW+1)'(head_q) + (LW+1)'(lh_q) - (LW+1)'(1);
    cur_row = (cur_sum >= (LW+1)'(RING_LINES)) ? RW'(cur_sum - (LW+1)'(RING_LINES))
                                               : RW'(cur_sum);
    adv_sum = (LW+1)'(head_q) + (LW+1)'(lh_q);
    adv_row = (adv_sum >= (LW+1)'(RING_LINES)) ? RW'(adv_sum - (LW+1)'(RING_LINES))
                                               : RW'(adv_sum);
    head_inc = (head_q == RW'(RING_LINES - 1)) ? '0 : head_q + 1'b1;
    row_dec  = (clr_row_q == '0) ? RW'(RING_LINES - 1) : clr_row_q - 1'b1;
    adv_full = (lh_q >= LW'(RING_LINES));
    adv_head = adv_full ? head_inc : head_q;
    adv_lh   = adv_full ? lh_q : lh_q + 1'b1;
    adv_vt   = (!adv_full && (lh_q >= VISIBLE_ROWS)) ? vt_q + 1'b1 : vt_q;
  end

  // carriage return span and view clamp
  always_comb begin
    lhm1     = lh_q - 1'b1;
    cr_w     = (wrap_q < lhm1) ? RW'(wrap_q) : RW'(lhm1);
    lh_cr    = lh_q - LW'(cr_w);
    maxv     = (lh_q > VISIBLE_ROWS) ? lh_q - LW'(VISIBLE_ROWS) : '0;
    vt_clamp = (vt_q > maxv) ? maxv : vt_q;
    mod_inc  = (col_mod_q == TMW'(TAB_STOP - 1)) ? '0 : col_mod_q + 1'b1;
  end

  always_comb begin
    ns    = SW'($signed({1'b0, vt_q})) + SW'(amt_q);
    smax  = SW'($signed({1'b0, lh_q})) - SW'(VISIBLE_ROWS);
    ns_cl = (ns > smax) ? smax : ns;
    if (ns_cl < 0) begin
      ns_cl = '0;
    end
    scroll_vt = LW'(ns_cl);
  end

  // print byte decode
  always_comb begin
    is_esc    = esc_q;
    is_nl     = (char_in_i == CH_N && esc_q) || char_in_i == CH_LF;
    is_cr     = (char_in_i == CH_R && esc_q) || char_in_i == CH_CR;
    is_tab    = (char_in_i == CH_T && esc_q) || char_in_i == CH_TAB;
    is_digit  = (char_in_i >= CH_ZERO) && (char_in_i <= CH_NINE);
    esc_plain = esc_q && (char_in_i != CH_DOLLAR) && (char_in_i != CH_BSLASH);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = blank;
    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = RESET_BLANK;
      end
      S_ROWCLR: begin
        mem_we   = 1'b1;
        mem_addr = {clr_row_q, ccol_q};
      end
      S_PUT: begin
        mem_we    = (col_q < COLUMNS);
        mem_addr  = {cur_row, CW'(col_q)};
        mem_wdata = {attr_q, put_ch_q};
      end
      S_RDMOD: begin
        mem_addr = {RW'(idx_q), rcol_q};
      end
      default: begin
      end
    endcase
  end

  ttsw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_SWEEP;
      ret_q            <= S_DONE;
      default_fg_q     <= DEFAULT_FG_RST;
      default_bg_q     <= DEFAULT_BG_RST;
      head_q           <= '0;
      lh_q             <= LW'(1);
      wrap_q           <= '0;
      col_q            <= '0;
      col_mod_q        <= '0;
      vt_q             <= '0;
      esc_q            <= 1'b0;
      color_q          <= 1'b0;
      attr_q           <= default_attr(DEFAULT_FG_RST, DEFAULT_BG_RST);
      sweep_q          <= '0;
      clr_row_q        <= '0;
      ccol_q           <= '0;
      rows_left_q      <= '0;
      put_ch_q         <= '0;
      put2_ch_q        <= '0;
      put2_q           <= 1'b0;
      tab_q            <= 1'b0;
      amt_q            <= '0;
      idx_q            <= '0;
      rcol_q           <= '0;
      cell_char_q      <= '0;
      cell_attr_q      <= '0;
      chg_q            <= 1'b0;
      done_o           <= 1'b0;
      cell_char_o      <= '0;
      cell_attr_o      <= '0;
      scroll_pos_o     <= '0;
      line_count_o     <= '0;
      scrolled_up_o    <= 1'b0;
      scroll_changed_o <= 1'b0;
    end else begin
      done_o <= (state_q == S_DONE);

      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_DEFAULT_FG: default_fg_q <= cfg_data_i;
          CFG_DEFAULT_BG: default_bg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            // a read past the columns keeps the blank, a ram read replaces it
            cell_char_q <= (op_e'(op_i) == OP_READ) ? blank[7:0] : 8'h00;
            cell_attr_q <= (op_e'(op_i) == OP_READ) ? blank[15:8] : 8'h00;
            chg_q       <= 1'b0;
            ccol_q      <= '0;
            ret_q       <= S_DONE;
            case (op_e'(op_i))
              OP_PRINT: begin
                if (char_in_i == CH_DOLLAR && !is_esc) begin
                  color_q <= 1'b1;
                  state_q <= S_DONE;
                end else if (char_in_i == CH_BSLASH && !is_esc) begin
                  esc_q   <= 1'b1;
                  state_q <= S_DONE;
                end else if (is_nl) begin
                  esc_q     <= 1'b0;
                  attr_q    <= dflt_attr;
                  wrap_q    <= '0;
                  head_q    <= adv_head;
                  lh_q      <= adv_lh;
                  vt_q      <= adv_vt;
                  col_q     <= '0;
                  col_mod_q <= '0;
                  clr_row_q <= adv_row;
                  state_q   <= S_ROWCLR;
                end else if (is_cr) begin
                  esc_q       <= 1'b0;
                  rows_left_q <= cr_w;
                  clr_row_q   <= cur_row;
                  lh_q        <= lh_cr;
                  wrap_q      <= '0;
                  col_q       <= '0;
                  col_mod_q   <= '0;
                  state_q     <= S_ROWCLR;
                end else if (is_tab) begin
                  esc_q    <= 1'b0;
                  put_ch_q <= CH_SPACE;
                  put2_q   <= 1'b0;
                  tab_q    <= 1'b1;
                  state_q  <= S_PUT;
                end else begin
                  esc_q <= 1'b0;
                  tab_q <= 1'b0;
                  if (color_q) begin
                    if (is_digit) begin
                      attr_q <= {attr_q[7:4], native_color(4'(char_in_i - CH_ZERO))};
                    end
                    color_q <= 1'b0;
                    state_q <= S_DONE;
                  end else if (esc_plain) begin
                    put_ch_q  <= CH_BSLASH;
                    put2_q    <= (char_in_i != CH_NUL);
                    put2_ch_q <= char_in_i;
                    state_q   <= S_PUT;
                  end else if (char_in_i != CH_NUL) begin
                    put_ch_q <= char_in_i;
                    put2_q   <= 1'b0;
                    state_q  <= S_PUT;
                  end else begin
                    state_q <= S_DONE;
                  end
                end
              end
              OP_NEWLINE: begin
                attr_q    <= dflt_attr;
                wrap_q    <= '0;
                head_q    <= adv_head;
                lh_q      <= adv_lh;
                vt_q      <= adv_vt;
                col_q     <= '0;
                col_mod_q <= '0;
                clr_row_q <= adv_row;
                state_q   <= S_ROWCLR;
              end
              OP_SCROLL: begin
                amt_q   <= scroll_amount_i;
                state_q <= S_SCROLL;
              end
              OP_READ: begin
                if (view_column_i >= COLUMNS) begin
                  state_q <= S_DONE;
                end else begin
                  idx_q   <= IW'(head_q) + IW'(vt_q) + IW'(view_row_i);
                  rcol_q  <= CW'(view_column_i);
                  state_q <= S_RDMOD;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end

        S_PUT: begin
          if (col_q >= COLUMNS) begin
            if (wrap_q != WRAP_MAX) begin
              wrap_q <= wrap_q + 1'b1;
            end
            head_q      <= adv_head;
            lh_q        <= adv_lh;
            vt_q        <= adv_vt;
            col_q       <= '0;
            col_mod_q   <= '0;
            clr_row_q   <= adv_row;
            ccol_q      <= '0;
            rows_left_q <= '0;
            ret_q       <= S_PUT;
            state_q     <= S_ROWCLR;
          end else begin
            col_q     <= col_q + 1'b1;
            col_mod_q <= mod_inc;
            if (put2_q) begin
              put_ch_q <= put2_ch_q;
              put2_q   <= 1'b0;
            end else if (!(tab_q && mod_inc != '0)) begin
              state_q <= S_DONE;
            end
          end
        end

        S_ROWCLR: begin
          if (ccol_q == CW'(COLUMNS - 1)) begin
            ccol_q <= '0;
            if (rows_left_q != '0) begin
              rows_left_q <= rows_left_q - 1'b1;
              clr_row_q   <= row_dec;
            end else begin
              state_q <= ret_q;
            end
          end else begin
            ccol_q <= ccol_q + 1'b1;
          end
        end

        S_SCROLL: begin
          vt_q    <= scroll_vt;
          chg_q   <= (scroll_vt != vt_q);
          state_q <= S_DONE;
        end

        S_RDMOD: begin
          if (idx_q >= IW'(RING_LINES)) begin
            idx_q <= idx_q - IW'(RING_LINES);
          end else begin
            state_q <= S_RDDATA;
          end
        end

        S_RDDATA: begin
          cell_char_q <= mem_rdata[7:0];
          cell_attr_q <= mem_rdata[15:8];
          state_q     <= S_DONE;
        end

        S_DONE: begin
          vt_q             <= vt_clamp;
          cell_char_o      <= cell_char_q;
          cell_attr_o      <= cell_attr_q;
          scroll_pos_o     <= 10'(vt_clamp);
          line_count_o     <= 11'(lh_q);
          scrolled_up_o    <= (vt_q < maxv);
          scroll_changed_o <= chg_q;
          state_q          <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_DONE))
    else $error("result beat without a finished command");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not occupy the unit");

  a_view_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (vt_q == '0 || (vt_q + VISIBLE_ROWS <= lh_q)))
    else $error("view top beyond the held lines");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
    else $error("cell write outside a write sequence");

endmodule

@@ rtl/ttsw_ram.sv @@
module ttsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ sim/text_terminal_scrollback_writer_unit_test.sv @@
module text_terminal_scrollback_writer_unit_test;
  import ttsw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int RING = RING_LINES_DEF;
  localparam int VIS = VISIBLE_ROWS_DEF;
  localparam int TABW = TAB_STOP_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int BACKLOG_DEPTH = 8192;
  // reset sweep, about 2000 commands, long gaps
  localparam int CYCLE_LIMIT = 3_000_000;

  localparam logic [3:0] PALETTE [10] = '{
    4'h0, 4'hF, 4'h9, 4'hA, 4'hC, 4'hB, 4'hE, 4'hD, 4'h6, 4'h7
  };

  typedef enum logic [1:0] {
    ENTRY_CMD,
    ENTRY_REG,
    ENTRY_PAUSE
  } entry_e;

  typedef struct packed {
    entry_e      kind;
    op_e         op;
    logic [7:0]  ch;
    logic [11:0] amt;
    logic [5:0]  vrow;
    logic [6:0]  vcol;
    cfg_e        reg_sel;
    logic [3:0]  reg_val;
  } command_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [9:0]  pos;
    logic [10:0] lines;
    logic        up;
    logic        moved;
    int unsigned tag;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = OP_PRINT;
  logic [7:0]  char_in_i = '0;
  logic [11:0] scroll_amount_i = '0;
  logic [5:0]  view_row_i = '0;
  logic [6:0]  view_column_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_DEFAULT_FG;
  logic [3:0]  cfg_data_i = '0;
  logic        done_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;
  logic [9:0]  scroll_pos_o;
  logic [10:0] line_count_o;
  logic        scrolled_up_o;
  logic        scroll_changed_o;

  command_t    command_backlog [BACKLOG_DEPTH];
  int unsigned backlog_wr = 0;
  int unsigned backlog_rd = 0;
  reply_t      replies_due [BACKLOG_DEPTH];
  int unsigned due_wr = 0;
  int unsigned due_rd = 0;
  command_t    active;
  int unsigned cycle_count = 0;
  int unsigned idle_left = 0;
  int unsigned calm_left = 0;
  int unsigned settle = 0;
  int unsigned mismatches = 0;

  // terminal state as the block should hold it
  logic [15:0] glyphs [RING*COLS];
  int unsigned head_row, held, wraps, col, top;
  bit          esc_armed, color_armed;
  logic [7:0]  pen_attr;
  logic [3:0]  fg_idx, bg_idx;

  text_terminal_scrollback_writer_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .char_in_i(char_in_i),
    .scroll_amount_i(scroll_amount_i),
    .view_row_i(view_row_i),
    .view_column_i(view_column_i),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .done_o(done_o),
    .cell_char_o(cell_char_o),
    .cell_attr_o(cell_attr_o),
    .scroll_pos_o(scroll_pos_o),
    .line_count_o(line_count_o),
    .scrolled_up_o(scrolled_up_o),
    .scroll_changed_o(scroll_changed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] palette(logic [3:0] idx);
    return PALETTE[(idx > 4'd9) ? 4'd9 : idx];
  endfunction

  function automatic logic [15:0] blank_cell();
    return {palette(bg_idx), palette(fg_idx), CH_SPACE};
  endfunction

  function automatic void wipe_row(int unsigned r);
    logic [15:0] b;
    int unsigned c;
    b = blank_cell();
    for (c = 0; c < COLS; c++) glyphs[r*COLS + c] = b;
  endfunction

  function automatic void advance_row();
    col = 0;
    if (held >= RING) begin
      head_row = (head_row + 1) % RING;
    end else begin
      held++;
      if (held > VIS) top++;
    end
    wipe_row((head_row + held - 1) % RING);
  endfunction

  function automatic void start_line();
    pen_attr = {palette(bg_idx), palette(fg_idx)};
    wraps = 0;
    advance_row();
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (col >= COLS) begin
      if (wraps < 1023) wraps++;
      advance_row();
    end
    glyphs[((head_row + held - 1) % RING)*COLS + col] = {pen_attr, ch};
    col++;
  endfunction

  function automatic void erase_line();
    int unsigned w, i, lim;
    w = (wraps > held - 1) ? held - 1 : wraps;
    for (i = 0; i <= w; i++) wipe_row((head_row + held - 1 - i) % RING);
    held -= w;
    wraps = 0;
    col = 0;
    lim = (held > VIS) ? held - VIS : 0;
    if (top > lim) top = lim;
  endfunction

  function automatic void tab_out();
    do begin
      put_char(CH_SPACE);
    end while (col % TABW != 0);
  endfunction

  function automatic void take_byte(logic [7:0] ch);
    bit esc;
    esc = esc_armed;
    if (ch == CH_DOLLAR && !esc) begin
      color_armed = 1'b1;
      return;
    end
    if (ch == CH_BSLASH && !esc) begin
      esc_armed = 1'b1;
      return;
    end
    if ((ch == CH_N && esc) || ch == CH_LF) begin
      start_line();
      esc_armed = 1'b0;
      return;
    end
    if ((ch == CH_R && esc) || ch == CH_CR) begin
      erase_line();
      esc_armed = 1'b0;
      return;
    end
    if ((ch == CH_T && esc) || ch == CH_TAB) begin
      tab_out();
      esc_armed = 1'b0;
      return;
    end
    if (ch == CH_DOLLAR || ch == CH_BSLASH) esc = 1'b0;
    if (color_armed) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) pen_attr[3:0] = palette(4'(ch - CH_ZERO));
      color_armed = 1'b0;
    end else begin
      if (esc) put_char(CH_BSLASH);
      if (ch != CH_NUL) put_char(ch);
    end
    esc_armed = 1'b0;
  endfunction

  function automatic reply_t run_command(command_t s);
    reply_t r;
    int ns, maxv;
    logic [15:0] stored;
    r = '0;
    case (s.op)
      OP_PRINT: take_byte(s.ch);
      OP_NEWLINE: start_line();
      OP_SCROLL: begin
        ns = int'(top) + int'($signed(s.amt));
        maxv = int'(held) - VIS;
        if (ns > maxv) ns = maxv;
        if (ns < 0) ns = 0;
        if (ns != int'(top)) begin
          top = ns;
          r.moved = 1'b1;
        end
      end
      default: begin
        if (s.vcol < COLS) stored = glyphs[((head_row + top + s.vrow) % RING)*COLS + s.vcol];
        else stored = blank_cell();
        r.ch = stored[7:0];
        r.attr = stored[15:8];
      end
    endcase
    r.pos = top[9:0];
    r.lines = held[10:0];
    r.up = (held > top) && (held - top > VIS);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    p = $urandom_range(99);
    if (p < 3) begin
      calm_left = $urandom_range(80, 20);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(20, 4);
    return $urandom_range(200, 30);
  endfunction

  function automatic void queue_command(command_t s);
    if (backlog_wr < BACKLOG_DEPTH) begin
      command_backlog[backlog_wr] = s;
      backlog_wr++;
    end
  endfunction

  function automatic command_t noisy(op_e op);
    command_t s;
    s.kind = ENTRY_CMD;
    s.op = op;
    s.ch = 8'($urandom);
    s.amt = 12'($urandom);
    s.vrow = 6'($urandom);
    s.vcol = 7'($urandom);
    s.reg_sel = CFG_DEFAULT_FG;
    s.reg_val = '0;
    return s;
  endfunction

  function automatic void add_print(logic [7:0] ch);
    command_t s;
    s = noisy(OP_PRINT);
    s.ch = ch;
    queue_command(s);
  endfunction

  function automatic void add_newline();
    queue_command(noisy(OP_NEWLINE));
  endfunction

  function automatic void add_scroll(logic [11:0] amt);
    command_t s;
    s = noisy(OP_SCROLL);
    s.amt = amt;
    queue_command(s);
  endfunction

  function automatic void add_read(logic [5:0] r, logic [6:0] c);
    command_t s;
    s = noisy(OP_READ);
    s.vrow = r;
    s.vcol = c;
    queue_command(s);
  endfunction

  // wait for every reply, then program both colors
  function automatic void add_setting(logic [3:0] fg, logic [3:0] bg);
    command_t s;
    s = '0;
    s.kind = ENTRY_PAUSE;
    queue_command(s);
    s.kind = ENTRY_REG;
    s.reg_sel = CFG_DEFAULT_FG;
    s.reg_val = fg;
    queue_command(s);
    s.reg_sel = CFG_DEFAULT_BG;
    s.reg_val = bg;
    queue_command(s);
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 35) return 8'($urandom_range(8'h7E, 8'h21));
    if (p < 45) return CH_BSLASH;
    if (p < 52) return CH_DOLLAR;
    if (p < 60) return 8'(CH_ZERO + $urandom_range(9));
    if (p < 64) return CH_N;
    if (p < 67) return CH_T;
    if (p < 69) return CH_R;
    if (p < 72) return CH_NUL;
    if (p < 74) return CH_LF;
    if (p < 75) return CH_CR;
    if (p < 77) return CH_TAB;
    if (p < 85) return CH_SPACE;
    return 8'($urandom);
  endfunction

  function automatic logic [11:0] pick_amount();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 12'(int'($urandom_range(120)) - 60);
    if (p < 75) return 12'(int'($urandom_range(2048)) - 1024);
    if (p < 90) return 12'($urandom);
    case ($urandom_range(3))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'(-1024);
      default: return 12'd1024;
    endcase
  endfunction

  function automatic void add_random_read();
    add_read(6'($urandom), ($urandom_range(99) < 60) ? 7'($urandom_range(15)) : 7'($urandom));
  endfunction

  function automatic void add_mixed();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) add_print(pick_char());
    else if (p < 70) add_newline();
    else if (p < 82) add_scroll(pick_amount());
    else add_random_read();
  endfunction

  // a line that can run long enough to wrap, closed by a carriage return or a newline
  function automatic void add_long_line();
    int unsigned n, i, p;
    n = $urandom_range(200, 60);
    for (i = 0; i < n; i++) begin
      p = $urandom_range(9);
      if (p < 4) begin
        add_print(CH_TAB);
      end else if (p < 8) begin
        add_print(8'($urandom_range(8'h7E, 8'h21)));
      end else if (p < 9) begin
        add_print(CH_DOLLAR);
        add_print(8'(CH_ZERO + $urandom_range(9)));
      end else begin
        add_random_read();
      end
    end
    p = $urandom_range(3);
    if (p < 2) begin
      add_print(CH_CR);
    end else if (p < 3) begin
      add_print(CH_BSLASH);
      add_print(CH_R);
    end else begin
      add_newline();
    end
  endfunction

  function automatic void add_mixed_phase(int unsigned n);
    int unsigned goal;
    goal = backlog_wr + n;
    while (backlog_wr < goal && backlog_wr < BACKLOG_DEPTH) begin
      if ($urandom_range(999) < 5) add_long_line();
      else add_mixed();
    end
  endfunction

  function automatic void add_fill_phase(int unsigned n);
    int unsigned i, p;
    for (i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 80) add_newline();
      else if (p < 90) add_random_read();
      else if (p < 95) add_scroll(pick_amount());
      else add_print(pick_char());
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    command_t nx;
    reply_t r;
    logic n_start, n_we;
    n_start = start;
    n_we = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        r = run_command(active);
        r.tag = cycle_count;
        replies_due[due_wr] = r;
        due_wr++;
        idle_left = pick_gap();
      end
      if (!start || !busy) begin
        n_start = 1'b0;
        if (idle_left != 0) begin
          idle_left--;
        end else if (backlog_rd != backlog_wr) begin
          nx = command_backlog[backlog_rd];
          case (nx.kind)
            ENTRY_CMD: begin
              backlog_rd++;
              active = nx;
              n_start = 1'b1;
              op_i <= nx.op;
              char_in_i <= nx.ch;
              scroll_amount_i <= nx.amt;
              view_row_i <= nx.vrow;
              view_column_i <= nx.vcol;
            end
            ENTRY_REG: begin
              backlog_rd++;
              n_we = 1'b1;
              cfg_index_i <= nx.reg_sel;
              cfg_data_i <= nx.reg_val;
              if (nx.reg_sel == CFG_DEFAULT_FG) fg_idx = nx.reg_val;
              else bg_idx = nx.reg_val;
            end
            default: begin
              if (due_rd == due_wr && !busy && !cfg_we_i) begin
                settle++;
                if (settle == SETTLE_CYCLES) begin
                  settle = 0;
                  backlog_rd++;
                end
              end else begin
                settle = 0;
              end
            end
          endcase
        end
      end
    end
    start <= n_start;
    cfg_we_i <= n_we;
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (due_rd == due_wr || replies_due[due_rd].tag >= cycle_count) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no command outstanding");
      end else begin
        want = replies_due[due_rd];
        due_rd++;
        if (want.ch !== cell_char_o || want.attr !== cell_attr_o ||
            want.pos !== scroll_pos_o || want.lines !== line_count_o ||
            want.up !== scrolled_up_o || want.moved !== scroll_changed_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch want/got: char %h/%h attr %h/%h pos %0d/%0d",
                     want.ch, cell_char_o, want.attr, cell_attr_o, want.pos, scroll_pos_o);
            $display("  lines %0d/%0d up %b/%b moved %b/%b", want.lines, line_count_o,
                     want.up, scrolled_up_o, want.moved, scroll_changed_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned r;
    fg_idx = DEFAULT_FG_RST;
    bg_idx = DEFAULT_BG_RST;
    head_row = 0;
    held = 1;
    wraps = 0;
    col = 0;
    top = 0;
    esc_armed = 1'b0;
    color_armed = 1'b0;
    pen_attr = {palette(bg_idx), palette(fg_idx)};
    for (r = 0; r < RING; r++) wipe_row(r);

    // directed: extremes, every op, escapes, colors, string end
    add_read(6'd0, 7'd0);
    add_read(6'd63, 7'd127);
    add_print(8'h41);
    add_print(8'hFF);
    add_print(CH_DOLLAR);
    add_print(8'h33);
    add_print(8'h42);
    add_print(CH_DOLLAR);
    add_print(8'h78);
    add_print(CH_BSLASH);
    add_print(CH_BSLASH);
    add_print(CH_BSLASH);
    add_print(CH_DOLLAR);
    add_print(CH_BSLASH);
    add_print(8'h71);
    add_print(CH_BSLASH);
    add_print(CH_NUL);
    add_print(CH_DOLLAR);
    add_print(CH_NUL);
    add_print(CH_TAB);
    add_print(CH_BSLASH);
    add_print(CH_N);
    add_scroll(12'h800);
    add_scroll(12'h7FF);
    add_print(CH_CR);
    add_newline();
    add_read(6'd62, 7'd5);

    add_setting(4'd0, 4'd15);
    add_mixed_phase(480);
    add_setting(4'd15, 4'd9);
    add_fill_phase(620);
    add_setting(4'($urandom), 4'($urandom));
    add_mixed_phase(520);
    add_setting(4'd9, 4'd0);
    add_mixed_phase(350);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (backlog_rd != backlog_wr || start || due_rd != due_wr) @(posedge clk_i);
    repeat (4 * COLS) @(posedge clk_i);
    if (mismatches == 0 && due_rd == due_wr) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ttsw_pkg.sv
rtl/ttsw_ram.sv
rtl/text_terminal_scrollback_writer_unit.sv
sim/text_terminal_scrollback_writer_unit_test.sv
